// File: sv/scet_pkg.sv
// Shared types and constants for the second-chance expiry table.
// Holds field widths, parameter defaults, opcode codes and the count limit.
// No dependencies.
package scet_pkg;

    // Fixed widths of the stream fields
    localparam int KEY_W     = 64;
    localparam int VALUE_W   = 32;
    localparam int OPCODE_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int S_DATA_W  = 96;
    localparam int M_DATA_W  = 8;

    // Defaults for the top-level parameters
    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    typedef logic [OPCODE_W-1:0] opcode_t;

    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_REMOVE = 2'd1;
    localparam opcode_t OP_SEARCH = 2'd2;
    localparam opcode_t OP_PRUNE  = 2'd3;

    typedef logic [COUNT_W-1:0] count_t;

    localparam count_t COUNT_MAX = 5'd31;

endpackage

// File: sv/scet_ram.sv
// Generic single-port RAM with registered read data.
// Used for the key and value store of the expiry table; depends on nothing.
module scet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: sv/second_chance_expiry_table_core.sv
// Second-chance expiry table: top level with the scan sequencer and mark bits.
// Depends on scet_pkg and scet_ram.
//
// A fixed-capacity key/value table with two-period aging. Each word on the
// input stream carries an operation in s_tuser (insert, remove, search, prune
// tick) and a key and value in s_tdata; each one yields exactly one result word.
// Every operation walks all ENTRIES slots through the single port of the
// key/value RAM and one comparator before the next word can be accepted. The
// result is held in an output register, so a new word may be accepted while
// it waits. A new key goes into the lowest free slot; an insert of a new key
// into a full table stores nothing and reports table_full. The table is empty
// after reset; there is no clearing pass, as valid, recent and hit marks are
// flip-flops cleared at once.
module second_chance_expiry_table_core
    import scet_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key[63:0], data_value[95:64]
    input  logic [OPCODE_W-1:0] s_tuser,   // opcode[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // answer[0], table_full[1],
                                           // evicted_count[6:2], zero[7]
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int RW = KEY_BITS + VALUE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [ENTRIES-1:0]    recent_reg, recent_next;
    logic [ENTRIES-1:0]    hit_reg, hit_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    opcode_t               op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  found_reg, found_next;
    logic [IW-1:0]         found_idx_reg, found_idx_next;
    logic                  eq_reg, eq_next;
    logic                  free_reg, free_next;
    logic [IW-1:0]         free_idx_reg, free_idx_next;
    count_t                count_reg, count_next;
    logic                  answer_reg, answer_next;
    logic                  full_reg, full_next;
    count_t                evicted_reg, evicted_next;

    logic                  ram_we;
    logic [IW-1:0]         ram_addr;
    logic [RW-1:0]         ram_rdata;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [IW-1:0]         slot;
    logic                  do_write;

    scet_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRIES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({val_reg, key_reg}),
        .rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[KEY_BITS-1:0];
    assign rd_val = ram_rdata[RW-1:KEY_BITS];

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        recent_next    = recent_reg;
        hit_next       = hit_reg;
        m_tvalid_next  = m_tvalid_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        eq_next        = eq_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        count_next     = count_reg;
        answer_next    = answer_reg;
        full_next      = full_reg;
        evicted_next   = evicted_reg;
        ram_we         = 1'b0;
        ram_addr       = cnt_reg[IW-1:0];
        do_write       = 1'b0;
        slot           = found_reg ? found_idx_reg : free_idx_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    key_next   = s_tdata[KEY_BITS-1:0];
                    val_next   = s_tdata[KEY_W +: VALUE_BITS];
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    eq_next    = 1'b0;
                    count_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // judge the slot whose read was issued last cycle
                if (pend_reg) begin
                    if (op_reg == OP_PRUNE) begin
                        if (valid_reg[idx_reg] && !recent_reg[idx_reg]) begin
                            valid_next[idx_reg] = 1'b0;
                            if (count_reg != COUNT_MAX) begin
                                count_next = count_reg + 5'd1;
                            end
                        end else if (valid_reg[idx_reg] && !hit_reg[idx_reg]) begin
                            recent_next[idx_reg] = 1'b0;
                        end
                    end else begin
                        if (valid_reg[idx_reg] && !found_reg && rd_key == key_reg) begin
                            found_next     = 1'b1;
                            found_idx_next = idx_reg;
                            eq_next        = (rd_val == val_reg);
                        end
                        if (!valid_reg[idx_reg] && !free_reg) begin
                            free_next     = 1'b1;
                            free_idx_next = idx_reg;
                        end
                    end
                end
                if (cnt_reg == CW'(ENTRIES)) begin
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    pend_next = 1'b1;
                    idx_next  = cnt_reg[IW-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                ram_addr = slot;
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    answer_next  = 1'b0;
                    full_next    = 1'b0;
                    evicted_next = '0;
                    unique case (op_reg)
                        OP_INSERT: begin
                            answer_next = !found_reg;
                            full_next   = !found_reg && !free_reg;
                            do_write    = found_reg || free_reg;
                        end
                        OP_REMOVE: begin
                            answer_next = found_reg;
                            if (found_reg) begin
                                valid_next[found_idx_reg]  = 1'b0;
                                recent_next[found_idx_reg] = 1'b0;
                                hit_next[found_idx_reg]    = 1'b0;
                            end
                        end
                        OP_SEARCH: begin
                            answer_next = found_reg && eq_reg;
                            if (found_reg) begin
                                recent_next[found_idx_reg] = 1'b1;
                                hit_next[found_idx_reg]    = 1'b1;
                            end
                        end
                        OP_PRUNE: begin
                            evicted_next = count_reg;
                            hit_next     = '0;
                        end
                    endcase
                    if (do_write) begin
                        ram_we            = 1'b1;
                        valid_next[slot]  = 1'b1;
                        recent_next[slot] = 1'b1;
                        hit_next[slot]    = 1'b1;
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            valid_reg    <= '0;
            recent_reg   <= '0;
            hit_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            valid_reg    <= valid_next;
            recent_reg   <= recent_next;
            hit_reg      <= hit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        op_reg        <= op_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        eq_reg        <= eq_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        count_reg     <= count_next;
        answer_reg    <= answer_next;
        full_reg      <= full_next;
        evicted_reg   <= evicted_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, evicted_reg, full_reg, answer_reg};

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the completion step");

    a_full_means_new: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && full_reg |-> answer_reg)
        else $error("table_full reported for a key that was present");

    a_evict_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (evicted_reg != '0) |-> !answer_reg && !full_reg)
        else $error("eviction count on a non-prune result");

    a_accept_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_SCAN && cnt_reg == '0)
        else $error("accepted word did not start a scan");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> cnt_reg <= CW'(ENTRIES))
        else $error("scan counter ran past the table");

endmodule

// File: bench/tb_second_chance_expiry_table_core.sv
`timescale 1ns / 1ps
// Self-checking bench for second_chance_expiry_table_core: a directed table, then
// random traffic, each result word compared with a built-in model of the table.
// Depends on scet_pkg and the RTL of the core.
module tb_second_chance_expiry_table_core;
    import scet_pkg::*;

    localparam int ENTRIES        = ENTRIES_DEF;
    localparam int HALF_PERIOD    = 6;
    localparam int RANDOM_ITEMS   = 900;
    localparam int SEGMENT_ITEMS  = 75;
    localparam int KEY_POOL       = 20;
    localparam int DRAIN_CYCLES   = ENTRIES + 8;
    localparam int TIMEOUT_CYCLES = 700_000;
    localparam int MAX_REPORTS    = 30;

    typedef struct packed {
        logic   answer;
        logic   table_full;
        count_t evicted;
    } table_result_t;

    typedef struct {
        opcode_t            op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        bit                 typed;
        table_result_t      result;
    } table_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [OPCODE_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    second_chance_expiry_table_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Model of the table contents
    logic               slot_valid  [ENTRIES];
    logic [KEY_W-1:0]   slot_key    [ENTRIES];
    logic [VALUE_W-1:0] slot_value  [ENTRIES];
    logic               slot_recent [ENTRIES];
    logic               slot_hit    [ENTRIES];

    table_result_t expected_results[$];
    table_row_t    sent_rows[$];
    table_row_t    directed_rows[$];

    logic [KEY_W-1:0]   key_pool   [KEY_POOL];
    logic [VALUE_W-1:0] value_pool [4];

    int  errors;
    int  results_checked;
    int  refusals_seen;
    int  evictions_seen;
    int  op_count [4];
    bit  source_steady;
    bit  sink_steady;
    int  stall_left = 0;

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Apply one operation to the model and work out its result word
    task automatic apply_table_op(input opcode_t op, input logic [KEY_W-1:0] key,
                                  input logic [VALUE_W-1:0] value,
                                  output table_result_t res);
        int match_idx;
        int free_idx;
        res       = '0;
        match_idx = -1;
        free_idx  = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && slot_key[i] == key && match_idx < 0)
                match_idx = i;
            if (!slot_valid[i] && free_idx < 0)
                free_idx = i;
        end
        case (op)
            OP_INSERT: begin
                if (match_idx < 0) begin
                    res.answer     = 1'b1;
                    res.table_full = (free_idx < 0);
                    match_idx      = free_idx;
                end
                if (match_idx >= 0) begin
                    slot_valid[match_idx]  = 1'b1;
                    slot_key[match_idx]    = key;
                    slot_value[match_idx]  = value;
                    slot_recent[match_idx] = 1'b1;
                    slot_hit[match_idx]    = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (match_idx >= 0) begin
                    res.answer             = 1'b1;
                    slot_valid[match_idx]  = 1'b0;
                    slot_recent[match_idx] = 1'b0;
                    slot_hit[match_idx]    = 1'b0;
                end
            end
            OP_SEARCH: begin
                if (match_idx >= 0) begin
                    slot_recent[match_idx] = 1'b1;
                    slot_hit[match_idx]    = 1'b1;
                    res.answer             = (slot_value[match_idx] == value);
                end
            end
            default: begin
                // Evict stale entries, age the ones not touched this period
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_valid[i]) begin
                        if (!slot_recent[i]) begin
                            slot_valid[i] = 1'b0;
                            if (res.evicted != COUNT_MAX)
                                res.evicted = res.evicted + 1'b1;
                        end else if (!slot_hit[i]) begin
                            slot_recent[i] = 1'b0;
                        end
                    end
                    slot_hit[i] = 1'b0;
                end
            end
        endcase
    endtask

    task automatic add_row(input opcode_t op, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] value, input bit typed,
                           input logic answer, input logic table_full,
                           input int evicted);
        table_row_t row;
        row.op                = op;
        row.key               = key;
        row.value             = value;
        row.typed             = typed;
        row.result.answer     = answer;
        row.result.table_full = table_full;
        row.result.evicted    = count_t'(evicted);
        directed_rows.push_back(row);
    endtask

    // Present one word and hold it until the core takes it
    task automatic send_word(input table_row_t row);
        int gap;
        gap = source_steady ? 0 : idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        sent_rows.push_back(row);
        s_tvalid <= 1'b1;
        s_tuser  <= row.op;
        s_tdata  <= {row.value, row.key};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!sink_steady && $urandom_range(0, 99) < 30)
                stall_left <= idle_length();
        end
    end

    // Predict on every accepted input word, check every accepted result word
    always @(posedge aclk) begin
        table_result_t predicted;
        table_result_t want;
        table_result_t got;
        table_row_t    row;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                apply_table_op(opcode_t'(s_tuser), s_tdata[KEY_W-1:0],
                               s_tdata[KEY_W +: VALUE_W], predicted);
                row = sent_rows.pop_front();
                if (row.typed)
                    predicted = row.result;
                expected_results.push_back(predicted);
                op_count[s_tuser]++;
            end
            if (m_tvalid && m_tready) begin
                got.answer     = m_tdata[0];
                got.table_full = m_tdata[1];
                got.evicted    = m_tdata[6:2];
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result word %h", $time, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.table_full)
                        refusals_seen++;
                    evictions_seen += got.evicted;
                    if (got.answer !== want.answer || got.table_full !== want.table_full
                            || got.evicted !== want.evicted || m_tdata[7] !== 1'b0) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"%0t: mismatch: expected answer=%0b full=%0b ",
                                      "evicted=%0d, got answer=%0b full=%0b ",
                                      "evicted=%0d spare=%0b"},
                                     $time, want.answer, want.table_full, want.evicted,
                                     got.answer, got.table_full, got.evicted, m_tdata[7]);
                    end
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
        $display("** second_chance_expiry_table_core: FAILED **");
        $finish;
    end

    initial begin
        table_row_t row;
        int         mode;
        int         pick;
        int         insert_lim;
        int         remove_lim;
        int         search_lim;

        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_INSERT;
        aresetn       = 1'b0;
        errors        = 0;
        source_steady = 1'b0;
        sink_steady   = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i]  = 1'b0;
            slot_key[i]    = '0;
            slot_value[i]  = '0;
            slot_recent[i] = 1'b0;
            slot_hit[i]    = 1'b0;
        end
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = {$urandom, $urandom};
        value_pool[0] = '0;
        value_pool[1] = '1;
        value_pool[2] = $urandom;
        value_pool[3] = $urandom;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty table: nothing to find, remove or evict
        add_row(OP_SEARCH, '0, '0, 1, 1'b0, 1'b0, 0);
        add_row(OP_REMOVE, '0, '0, 1, 1'b0, 1'b0, 0);
        add_row(OP_PRUNE,  '1, '1, 1, 1'b0, 1'b0, 0);
        // Extreme keys and values, then an overwrite
        add_row(OP_INSERT, '0, '0, 1, 1'b1, 1'b0, 0);
        add_row(OP_INSERT, '1, '1, 1, 1'b1, 1'b0, 0);
        add_row(OP_SEARCH, '1, '1, 0, 1'b0, 1'b0, 0);
        add_row(OP_SEARCH, '1, '0, 0, 1'b0, 1'b0, 0);
        add_row(OP_INSERT, '0, 32'h0000_0005, 0, 1'b0, 1'b0, 0);
        // Fill the remaining slots, then offer one key too many
        for (int k = 1; k <= ENTRIES - 2; k++)
            add_row(OP_INSERT, 64'(k) << (4 * k), 32'(k), 0, 1'b0, 1'b0, 0);
        add_row(OP_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1, 1'b1, 1'b1, 0);
        // Two ticks age everything, the third evicts the whole table
        add_row(OP_PRUNE, '0, '0, 0, 1'b0, 1'b0, 0);
        add_row(OP_PRUNE, '0, '0, 0, 1'b0, 1'b0, 0);
        add_row(OP_PRUNE, '0, '0, 1, 1'b0, 1'b0, ENTRIES);
        add_row(OP_SEARCH, '0, 32'h0000_0005, 0, 1'b0, 1'b0, 0);
        add_row(OP_INSERT, 64'h8000_0000_0000_0001, 32'h8000_0000, 0, 1'b0, 1'b0, 0);
        add_row(OP_REMOVE, 64'h8000_0000_0000_0001, '0, 0, 1'b0, 1'b0, 0);

        foreach (directed_rows[i])
            send_word(directed_rows[i]);

        insert_lim = 40;
        remove_lim = 55;
        search_lim = 88;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SEGMENT_ITEMS == 0) begin
                // Change traffic mix and idling per segment
                mode          = $urandom_range(0, 2);
                source_steady = ($urandom_range(0, 4) == 0);
                sink_steady   = ($urandom_range(0, 4) == 0);
                key_pool[$urandom_range(0, KEY_POOL - 1)] = {$urandom, $urandom};
                case (mode)
                    0: begin
                        insert_lim = 40; remove_lim = 55; search_lim = 88;
                    end
                    1: begin
                        insert_lim = 60; remove_lim = 65; search_lim = 95;
                    end
                    default: begin
                        insert_lim = 30; remove_lim = 50; search_lim = 75;
                    end
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < insert_lim)
                row.op = OP_INSERT;
            else if (pick < remove_lim)
                row.op = OP_REMOVE;
            else if (pick < search_lim)
                row.op = OP_SEARCH;
            else
                row.op = OP_PRUNE;
            row.key    = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                     : key_pool[$urandom_range(0, KEY_POOL - 1)];
            row.value  = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom)
                                                     : value_pool[$urandom_range(0, 3)];
            row.typed  = 1'b0;
            row.result = '0;
            send_word(row);
        end
        s_tvalid <= 1'b0;
        // let the checker queue the last accepted word before draining
        @(posedge aclk);

        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d inserts, %0d removes, %0d searches, %0d prune ticks.",
                 op_count[OP_INSERT], op_count[OP_REMOVE], op_count[OP_SEARCH],
                 op_count[OP_PRUNE]);
        $display("Checked %0d result words: %0d refused inserts, %0d entries evicted.",
                 results_checked, refusals_seen, evictions_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("** second_chance_expiry_table_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never arrived", errors,
                     expected_results.size());
            $display("** second_chance_expiry_table_core: FAILED **");
        end
        $finish;
    end

endmodule
